// ===== rtl/dcs_pkg.sv =====
// Shared types and constants for the distance constraint solver.
`timescale 1ns / 1ps

package dcs_pkg;

    // Fixed widths of the coordinates, configuration registers and inverse masses.
    localparam int COORD_W = 32;
    localparam int STIFF_W = 17;
    localparam int REST_W  = 31;
    localparam int MASS_W  = 32;
    localparam int FRAC_W  = 16;

    // Configuration register indexes.
    localparam logic CFG_STIFFNESS   = 1'b0;
    localparam logic CFG_REST_LENGTH = 1'b1;

    // Configuration write request.
    typedef struct packed {
        logic [0:0]  index;
        logic [31:0] data;
    } cfg_req_t;

    // One constraint request.
    typedef struct packed {
        logic signed [COORD_W-1:0] first_x;
        logic signed [COORD_W-1:0] first_y;
        logic signed [COORD_W-1:0] second_x;
        logic signed [COORD_W-1:0] second_y;
        logic [MASS_W-1:0]         first_inv_mass;
        logic [MASS_W-1:0]         second_inv_mass;
    } dcs_in_t;

    // One correction result.
    typedef struct packed {
        logic signed [COORD_W-1:0] first_dx;
        logic signed [COORD_W-1:0] first_dy;
        logic signed [COORD_W-1:0] second_dx;
        logic signed [COORD_W-1:0] second_dy;
    } dcs_out_t;

endpackage

// ===== rtl/dcs_divider.sv =====
// Pipelined restoring divider, one quotient bit per stage.
`timescale 1ns / 1ps

module dcs_divider #(
    parameter int NUM_W = 64,
    parameter int DEN_W = 33,
    parameter int TAG_W = 8
) (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             in_valid,
    input  logic [NUM_W-1:0] num,
    input  logic [DEN_W-1:0] den,
    input  logic [TAG_W-1:0] tag_in,
    output logic             out_valid,
    output logic [NUM_W-1:0] quot,
    output logic [TAG_W-1:0] tag_out
);

    // Per-stage registers: remainder, shifting numerator/quotient, divisor.
    logic [NUM_W:0]     vld_reg;
    logic [DEN_W:0]     rem_reg [NUM_W+1];
    logic [NUM_W-1:0]   nq_reg  [NUM_W+1];
    logic [DEN_W-1:0]   den_reg [NUM_W+1];
    logic [TAG_W-1:0]   tag_reg [NUM_W+1];

    assign vld_reg[0] = in_valid;
    assign rem_reg[0] = '0;
    assign nq_reg[0]  = num;
    assign den_reg[0] = den;
    assign tag_reg[0] = tag_in;

    // Each stage shifts in one numerator bit and produces one quotient bit.
    for (genvar i = 0; i < NUM_W; i++) begin : g_stage
        logic [DEN_W:0] shifted;
        logic [DEN_W:0] trial;
        logic           take;
        assign shifted = {rem_reg[i][DEN_W-1:0], nq_reg[i][NUM_W-1]};
        assign trial   = shifted - {1'b0, den_reg[i]};
        assign take    = (shifted >= {1'b0, den_reg[i]});

        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
            begin
                vld_reg[i+1] <= 1'b0;
            end
            else
            begin
                vld_reg[i+1] <= vld_reg[i];
            end
        end

        always_ff @(posedge clk)
        begin
            rem_reg[i+1] <= take ? trial : shifted;
            nq_reg[i+1]  <= {nq_reg[i][NUM_W-2:0], take};
            den_reg[i+1] <= den_reg[i];
            tag_reg[i+1] <= tag_reg[i];
        end
    end

    assign out_valid = vld_reg[NUM_W];
    assign quot      = nq_reg[NUM_W];
    assign tag_out   = tag_reg[NUM_W];

endmodule

// ===== rtl/distance_constraint_solve.sv =====
// Top level of the pipelined distance constraint solver.
// A request passes the input and square stages, the square root, gain stages and two dividers
// before the result strobe rises.
// Throughput one request per cycle; busy never rises and results cannot be stalled.
// Reset clears all valid bits; stiffness resets to 1.0 and rest length to zero.
`timescale 1ns / 1ps

module distance_constraint_solve (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                start,
    output logic                busy,
    input  dcs_pkg::dcs_in_t    req,
    output logic                done,
    output dcs_pkg::dcs_out_t   result,
    input  logic                cfg_valid,
    output logic                cfg_ready,
    input  dcs_pkg::cfg_req_t   cfg
);
    import dcs_pkg::*;

    localparam int CW   = COORD_W;
    localparam int DW   = CW + 1;          // coordinate difference
    localparam int SQW  = 2 * DW + 1;      // radicand
    localparam int LW   = DW + 1;          // length
    localparam int GW   = 64;              // unused width constant
    localparam int TOTW = MASS_W + 1;
    localparam int TW   = 2 * DW + 4;      // tag: mx, my, signs, zero, dneg

    assign busy      = 1'b0;
    assign cfg_ready = 1'b1;

    // Configuration registers.
    logic [STIFF_W-1:0] stiff_reg;
    logic [REST_W-1:0]  rest_reg;
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            stiff_reg <= STIFF_W'(1 << FRAC_W);
            rest_reg  <= '0;
        end
        else if (cfg_valid)
        begin
            unique case (cfg.index)
                CFG_STIFFNESS:   stiff_reg <= cfg.data[STIFF_W-1:0];
                CFG_REST_LENGTH: rest_reg  <= cfg.data[REST_W-1:0];
                default:         ;
            endcase
        end
    end

    // Stage 1: differences, magnitudes, signs and the inverse masses.
    logic               s1_vld_reg;
    logic [DW-1:0]      s1_mx_reg, s1_my_reg;
    logic               s1_nx_reg, s1_ny_reg;
    logic [MASS_W-1:0]  s1_ia_reg, s1_ib_reg;
    logic signed [DW-1:0] dx_c, dy_c;
    assign dx_c = DW'(signed'(req.second_x[CW-1:0])) - DW'(signed'(req.first_x[CW-1:0]));
    assign dy_c = DW'(signed'(req.second_y[CW-1:0])) - DW'(signed'(req.first_y[CW-1:0]));

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) s1_vld_reg <= 1'b0;
        else        s1_vld_reg <= start;
    end
    always_ff @(posedge clk)
    begin
        s1_mx_reg <= dx_c[DW-1] ? DW'(-dx_c) : DW'(dx_c);
        s1_my_reg <= dy_c[DW-1] ? DW'(-dy_c) : DW'(dy_c);
        s1_nx_reg <= dx_c[DW-1];
        s1_ny_reg <= dy_c[DW-1];
        s1_ia_reg <= req.first_inv_mass;
        s1_ib_reg <= req.second_inv_mass;
    end

    // Stage 2: squares.
    logic               s2_vld_reg;
    logic [2*DW-1:0]    s2_sx_reg, s2_sy_reg;
    logic [DW-1:0]      s2_mx_reg, s2_my_reg;
    logic               s2_nx_reg, s2_ny_reg;
    logic [MASS_W-1:0]  s2_ia_reg, s2_ib_reg;
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) s2_vld_reg <= 1'b0;
        else        s2_vld_reg <= s1_vld_reg;
    end
    always_ff @(posedge clk)
    begin
        s2_sx_reg <= s1_mx_reg * s1_mx_reg;
        s2_sy_reg <= s1_my_reg * s1_my_reg;
        s2_mx_reg <= s1_mx_reg;
        s2_my_reg <= s1_my_reg;
        s2_nx_reg <= s1_nx_reg;
        s2_ny_reg <= s1_ny_reg;
        s2_ia_reg <= s1_ia_reg;
        s2_ib_reg <= s1_ib_reg;
    end

    // Square root pipeline: one result bit per stage.
    localparam int RB = LW;
    logic              sq_vld_reg [RB+1];
    logic [SQW-1:0]    sq_s_reg   [RB+1];
    logic [LW-1:0]     sq_x_reg   [RB+1];
    logic [DW-1:0]     sq_mx_reg  [RB+1];
    logic [DW-1:0]     sq_my_reg  [RB+1];
    logic [1:0]        sq_sg_reg  [RB+1];
    logic [MASS_W-1:0] sq_ia_reg  [RB+1];
    logic [MASS_W-1:0] sq_ib_reg  [RB+1];

    assign sq_vld_reg[0] = s2_vld_reg;
    assign sq_s_reg[0]   = SQW'(s2_sx_reg) + SQW'(s2_sy_reg);
    assign sq_x_reg[0]   = '0;
    assign sq_mx_reg[0]  = s2_mx_reg;
    assign sq_my_reg[0]  = s2_my_reg;
    assign sq_sg_reg[0]  = {s2_nx_reg, s2_ny_reg};
    assign sq_ia_reg[0]  = s2_ia_reg;
    assign sq_ib_reg[0]  = s2_ib_reg;

    for (genvar k = 0; k < RB; k++) begin : g_sqrt
        logic [LW-1:0]  y;
        logic [2*LW-1:0] yy;
        assign y  = sq_x_reg[k] | (LW'(1) << (RB - 1 - k));
        assign yy = y * y;
        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n) sq_vld_reg[k+1] <= 1'b0;
            else        sq_vld_reg[k+1] <= sq_vld_reg[k];
        end
        always_ff @(posedge clk)
        begin
            sq_x_reg[k+1]  <= ((2*LW)'(sq_s_reg[k]) >= yy) ? y : sq_x_reg[k];
            sq_s_reg[k+1]  <= sq_s_reg[k];
            sq_mx_reg[k+1] <= sq_mx_reg[k];
            sq_my_reg[k+1] <= sq_my_reg[k];
            sq_sg_reg[k+1] <= sq_sg_reg[k];
            sq_ia_reg[k+1] <= sq_ia_reg[k];
            sq_ib_reg[k+1] <= sq_ib_reg[k];
        end
    end

    // Stage 3: difference from rest length, its product with stiffness, and zero checks.
    logic [LW-1:0]  len_c;
    logic           dneg_c, zero_c;
    logic [LW-1:0]  dmag_c;
    logic [TOTW-1:0] tot_c;
    assign len_c  = sq_x_reg[RB];
    assign dneg_c = len_c < LW'(rest_reg);
    assign dmag_c = dneg_c ? LW'(rest_reg) - len_c : len_c - LW'(rest_reg);
    assign tot_c  = TOTW'(sq_ia_reg[RB]) + TOTW'(sq_ib_reg[RB]);
    assign zero_c = (len_c == '0) || (len_c == LW'(rest_reg)) || (tot_c == '0);

    logic              s3_vld_reg;
    logic [LW+STIFF_W-1:0] s3_gs_reg;
    logic [LW-1:0]     s3_len_reg;
    logic [TOTW-1:0]   s3_tot_reg;
    logic [MASS_W-1:0] s3_ia_reg, s3_ib_reg;
    logic [TW-1:0]     s3_tag_reg;
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) s3_vld_reg <= 1'b0;
        else        s3_vld_reg <= sq_vld_reg[RB];
    end
    always_ff @(posedge clk)
    begin
        s3_gs_reg  <= dmag_c * stiff_reg;
        s3_len_reg <= (len_c == '0) ? LW'(1) : len_c;
        s3_tot_reg <= (tot_c == '0) ? TOTW'(1) : tot_c;
        s3_ia_reg  <= sq_ia_reg[RB];
        s3_ib_reg  <= sq_ib_reg[RB];
        s3_tag_reg <= {sq_mx_reg[RB], sq_my_reg[RB], sq_sg_reg[RB], zero_c, dneg_c};
    end

    // Stage 4: gain times inverse masses.
    localparam int GMW = LW + STIFF_W - FRAC_W;
    localparam int PW  = GMW + MASS_W;
    logic [GMW-1:0] g_c;
    assign g_c = s3_gs_reg[LW+STIFF_W-1:FRAC_W];

    logic              s4_vld_reg;
    logic [PW-1:0]     s4_pa_reg, s4_pb_reg;
    logic [TOTW-1:0]   s4_tot_reg;
    logic [LW-1:0]     s4_len_reg;
    logic [TW-1:0]     s4_tag_reg;
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) s4_vld_reg <= 1'b0;
        else        s4_vld_reg <= s3_vld_reg;
    end
    always_ff @(posedge clk)
    begin
        s4_pa_reg  <= g_c * s3_ia_reg;
        s4_pb_reg  <= g_c * s3_ib_reg;
        s4_tot_reg <= s3_tot_reg;
        s4_len_reg <= s3_len_reg;
        s4_tag_reg <= s3_tag_reg;
    end

    // Split by total inverse mass.
    localparam int DTW = LW + TW;
    logic             da_vld, db_vld;
    logic [PW-1:0]    ga_q, gb_q;
    logic [DTW-1:0]   da_tag;
    logic             db_tag;
    dcs_divider #(.NUM_W(PW), .DEN_W(TOTW), .TAG_W(DTW)) u_div_a (
        .clk(clk), .rst_n(rst_n), .in_valid(s4_vld_reg), .num(s4_pa_reg),
        .den(s4_tot_reg), .tag_in({s4_len_reg, s4_tag_reg}),
        .out_valid(da_vld), .quot(ga_q), .tag_out(da_tag));
    dcs_divider #(.NUM_W(PW), .DEN_W(TOTW), .TAG_W(1)) u_div_b (
        .clk(clk), .rst_n(rst_n), .in_valid(s4_vld_reg), .num(s4_pb_reg),
        .den(s4_tot_reg), .tag_in(1'b0),
        .out_valid(db_vld), .quot(gb_q), .tag_out(db_tag));

    // Shares do not exceed the gain, so GMW bits hold them.
    logic [LW-1:0]  d_len;
    logic [DW-1:0]  d_mx, d_my;
    logic           d_nx, d_ny, d_zero, d_neg;
    assign {d_len, d_mx, d_my, d_nx, d_ny, d_zero, d_neg} = da_tag;

    // Stage 5: component products, registered before the length divide.
    localparam int CPW = GMW + DW;
    logic            s5_vld_reg;
    logic [CPW-1:0]  s5_ax_reg, s5_ay_reg, s5_bx_reg, s5_by_reg;
    logic [LW-1:0]   s5_len_reg;
    logic [3:0]      s5_neg_reg;
    logic            s5_zero_reg;
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) s5_vld_reg <= 1'b0;
        else        s5_vld_reg <= da_vld & db_vld;
    end
    always_ff @(posedge clk)
    begin
        s5_ax_reg   <= ga_q[GMW-1:0] * d_mx;
        s5_ay_reg   <= ga_q[GMW-1:0] * d_my;
        s5_bx_reg   <= gb_q[GMW-1:0] * d_mx;
        s5_by_reg   <= gb_q[GMW-1:0] * d_my;
        s5_len_reg  <= d_len;
        s5_neg_reg  <= {d_neg != d_nx, d_neg != d_ny, d_neg == d_nx, d_neg == d_ny};
        s5_zero_reg <= d_zero;
    end

    // Divide the four components by the length.
    logic [3:0]     dv_vld;
    logic [CPW-1:0] dv_q [4];
    logic [4:0]     dv_tag;
    logic [4:0]     dv_unused [3];
    dcs_divider #(.NUM_W(CPW), .DEN_W(LW), .TAG_W(5)) u_div_ax (
        .clk(clk), .rst_n(rst_n), .in_valid(s5_vld_reg), .num(s5_ax_reg),
        .den(s5_len_reg), .tag_in({s5_neg_reg, s5_zero_reg}),
        .out_valid(dv_vld[0]), .quot(dv_q[0]), .tag_out(dv_tag));
    dcs_divider #(.NUM_W(CPW), .DEN_W(LW), .TAG_W(5)) u_div_ay (
        .clk(clk), .rst_n(rst_n), .in_valid(s5_vld_reg), .num(s5_ay_reg),
        .den(s5_len_reg), .tag_in('0),
        .out_valid(dv_vld[1]), .quot(dv_q[1]), .tag_out(dv_unused[0]));
    dcs_divider #(.NUM_W(CPW), .DEN_W(LW), .TAG_W(5)) u_div_bx (
        .clk(clk), .rst_n(rst_n), .in_valid(s5_vld_reg), .num(s5_bx_reg),
        .den(s5_len_reg), .tag_in('0),
        .out_valid(dv_vld[2]), .quot(dv_q[2]), .tag_out(dv_unused[1]));
    dcs_divider #(.NUM_W(CPW), .DEN_W(LW), .TAG_W(5)) u_div_by (
        .clk(clk), .rst_n(rst_n), .in_valid(s5_vld_reg), .num(s5_by_reg),
        .den(s5_len_reg), .tag_in('0),
        .out_valid(dv_vld[3]), .quot(dv_q[3]), .tag_out(dv_unused[2]));

    // Saturate one signed magnitude to the coordinate range.
    function automatic logic [CW-1:0] sat(input logic [CPW-1:0] mag, input logic neg,
                                          input logic zero);
        logic [CPW:0] lim;
        logic [CPW:0] m;
        lim = (CPW+1)'(1) << (CW - 1);
        m   = {1'b0, mag};
        if (zero)
            return '0;
        if (neg)
        begin
            if (m > lim) m = lim;
            return CW'(-m);
        end
        if (m > lim - 1'b1) m = lim - 1'b1;
        return CW'(m);
    endfunction

    // Output register.
    logic           done_reg;
    logic [CW-1:0]  o_reg [4];
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) done_reg <= 1'b0;
        else        done_reg <= dv_vld[0];
    end
    always_ff @(posedge clk)
    begin
        o_reg[0] <= sat(dv_q[0], dv_tag[4], dv_tag[0]);
        o_reg[1] <= sat(dv_q[1], dv_tag[3], dv_tag[0]);
        o_reg[2] <= sat(dv_q[2], dv_tag[2], dv_tag[0]);
        o_reg[3] <= sat(dv_q[3], dv_tag[1], dv_tag[0]);
    end

    assign done = done_reg;
    always_comb
    begin
        result           = '0;
        result.first_dx  = o_reg[0];
        result.first_dy  = o_reg[1];
        result.second_dx = o_reg[2];
        result.second_dy = o_reg[3];
    end

`ifndef SYNTHESIS
    // All four component dividers run in lockstep.
    a_lockstep: assert property (@(posedge clk) disable iff (!rst_n)
        dv_vld[0] == dv_vld[1] && dv_vld[0] == dv_vld[2] && dv_vld[0] == dv_vld[3])
        else $error("component dividers out of step");
    // Both mass dividers run in lockstep.
    a_mass_step: assert property (@(posedge clk) disable iff (!rst_n) da_vld == db_vld)
        else $error("mass dividers out of step");
    // A result follows a divider output in the next cycle.
    a_done: assert property (@(posedge clk) disable iff (!rst_n) dv_vld[0] |=> done)
        else $error("result lost");
`endif

endmodule

// ===== sim/distance_constraint_solve_tb.sv =====
// Self-checking testbench for the distance constraint solver.
`timescale 1ns / 1ps

module distance_constraint_solve_tb;
    import dcs_pkg::*;

    localparam int LATENCY_WAIT = 400;

    // One directed request, with a hand-written correction where it is obvious.
    typedef struct {
        dcs_in_t  item;
        bit       fixed;
        dcs_out_t corr;
    } row_t;

    logic     clk = 1'b0;
    logic     rst_n = 1'b0;
    logic     start = 1'b0;
    logic     busy;
    dcs_in_t  req = '0;
    logic     done;
    dcs_out_t result;
    logic     cfg_valid = 1'b0;
    logic     cfg_ready;
    cfg_req_t cfg = '0;

    // Shadow copy of the configuration registers.
    logic [16:0] stiff_shadow = 17'd65536;
    logic [30:0] rest_shadow = '0;

    // Hand-written correction for the request being offered, if any.
    bit       cur_fixed = 1'b0;
    dcs_out_t cur_corr = '0;

    dcs_out_t pending_corr[$];
    int       errors = 0;
    row_t     rows[$];

    distance_constraint_solve uut (
        .clk(clk), .rst_n(rst_n), .start(start), .busy(busy), .req(req),
        .done(done), .result(result), .cfg_valid(cfg_valid),
        .cfg_ready(cfg_ready), .cfg(cfg)
    );

    always #4 clk = ~clk;

    // Clamp a signed magnitude into the 32-bit two's complement range.
    function automatic logic [31:0] clamp_coord(logic [127:0] mag, logic neg);
        if (neg)
        begin
            if (mag > 128'h8000_0000)
                mag = 128'h8000_0000;
            return 32'(-mag);
        end
        if (mag > 128'h7FFF_FFFF)
            mag = 128'h7FFF_FFFF;
        return mag[31:0];
    endfunction

    // Correction computed with exact wide integer arithmetic.
    function automatic dcs_out_t correction(dcs_in_t r, logic [16:0] stiff,
                                            logic [30:0] rest);
        logic signed [33:0] dx;
        logic signed [33:0] dy;
        logic [33:0]  ax;
        logic [33:0]  ay;
        logic [127:0] mx, my, sq, len, probe, total, dmag, g, ga, gb;
        logic         dneg;
        dcs_out_t     o;
        o = '0;
        dx = {{2{r.second_x[31]}}, r.second_x} - {{2{r.first_x[31]}}, r.first_x};
        dy = {{2{r.second_y[31]}}, r.second_y} - {{2{r.first_y[31]}}, r.first_y};
        ax = dx[33] ? -dx : dx;
        ay = dy[33] ? -dy : dy;
        mx = 128'(ax);
        my = 128'(ay);
        sq = mx * mx + my * my;
        len = '0;
        for (int i = 63; i >= 0; i--)
        begin
            probe = len | (128'd1 << i);
            if (probe * probe <= sq)
                len = probe;
        end
        total = 128'(r.first_inv_mass) + 128'(r.second_inv_mass);
        if (len == 0 || len == 128'(rest) || total == 0)
            return o;
        dneg = len < 128'(rest);
        dmag = dneg ? 128'(rest) - len : len - 128'(rest);
        g  = (dmag * 128'(stiff)) / 128'd65536;
        ga = (g * 128'(r.first_inv_mass)) / total;
        gb = (g * 128'(r.second_inv_mass)) / total;
        o.first_dx  = clamp_coord((ga * mx) / len, dneg != dx[33]);
        o.first_dy  = clamp_coord((ga * my) / len, dneg != dy[33]);
        o.second_dx = clamp_coord((gb * mx) / len, dneg == dx[33]);
        o.second_dy = clamp_coord((gb * my) / len, dneg == dy[33]);
        return o;
    endfunction

    // Record each accepted request and check each result against the oldest one.
    always @(posedge clk)
    begin
        dcs_out_t want;
        if (cfg_valid && cfg_ready)
        begin
            if (cfg.index == CFG_STIFFNESS)
                stiff_shadow <= cfg.data[16:0];
            else if (cfg.index == CFG_REST_LENGTH)
                rest_shadow <= cfg.data[30:0];
        end
        if (start && !busy)
            pending_corr.push_back(cur_fixed ? cur_corr :
                                   correction(req, stiff_shadow, rest_shadow));
        if (done)
        begin
            if (pending_corr.size() == 0)
            begin
                $error("result with no request outstanding");
                errors++;
            end
            else
            begin
                want = pending_corr.pop_front();
                if (result.first_dx !== want.first_dx)
                begin
                    $error("first_dx expected %h got %h", want.first_dx, result.first_dx);
                    errors++;
                end
                if (result.first_dy !== want.first_dy)
                begin
                    $error("first_dy expected %h got %h", want.first_dy, result.first_dy);
                    errors++;
                end
                if (result.second_dx !== want.second_dx)
                begin
                    $error("second_dx expected %h got %h", want.second_dx, result.second_dx);
                    errors++;
                end
                if (result.second_dy !== want.second_dy)
                begin
                    $error("second_dy expected %h got %h", want.second_dy, result.second_dy);
                    errors++;
                end
            end
        end
    end

    // Offer one request and hold it until it is taken.
    task automatic send(dcs_in_t it, bit fixed, dcs_out_t corr);
        start <= 1'b1;
        req <= it;
        cur_fixed <= fixed;
        cur_corr <= corr;
        do
            @(posedge clk);
        while (busy);
    endtask

    // Randomly drop start after a request, with the given percent chance.
    task automatic sender_gap(int pct);
        if ($urandom_range(99) < pct)
        begin
            start <= 1'b0;
            repeat ($urandom_range(1, 5)) @(posedge clk);
        end
    endtask

    // Let every outstanding result arrive, then let the pipeline settle.
    task automatic drain();
        start <= 1'b0;
        while (pending_corr.size() != 0)
            @(posedge clk);
        repeat (LATENCY_WAIT) @(posedge clk);
    endtask

    task automatic write_reg(logic [0:0] idx, logic [31:0] val);
        cfg_valid <= 1'b1;
        cfg <= '{index: idx, data: val};
        do
            @(posedge clk);
        while (!cfg_ready);
        cfg_valid <= 1'b0;
        @(posedge clk);
    endtask

    function automatic row_t mk(int ax, int ay, int bx, int by, int unsigned ma,
                                int unsigned mb, bit fixed, dcs_out_t corr);
        row_t r;
        r.item = '{first_x: ax, first_y: ay, second_x: bx, second_y: by,
                   first_inv_mass: ma, second_inv_mass: mb};
        r.fixed = fixed;
        r.corr = corr;
        return r;
    endfunction

    // Random request: mostly nearby bodies, some full range and some coincident.
    function automatic dcs_in_t rand_item();
        dcs_in_t it;
        int unsigned kind;
        int unsigned span;
        it.first_x = $urandom;
        it.first_y = $urandom;
        kind = $urandom_range(9);
        span = 32'd1 << $urandom_range(4, 24);
        if (kind < 3)
        begin
            it.second_x = $urandom;
            it.second_y = $urandom;
        end
        else
        begin
            it.second_x = it.first_x + int'($urandom_range(span)) - int'(span / 2);
            it.second_y = it.first_y + int'($urandom_range(span)) - int'(span / 2);
        end
        if (kind == 9)
        begin
            it.second_x = it.first_x;
            it.second_y = it.first_y;
        end
        case ($urandom_range(5))
            0: it.first_inv_mass = 0;
            1: it.first_inv_mass = 32'hFFFF_FFFF;
            2: it.first_inv_mass = $urandom;
            default: it.first_inv_mass = $urandom_range(1 << 18);
        endcase
        case ($urandom_range(5))
            0: it.second_inv_mass = 0;
            1: it.second_inv_mass = 32'hFFFF_FFFF;
            2: it.second_inv_mass = $urandom;
            default: it.second_inv_mass = $urandom_range(1 << 18);
        endcase
        return it;
    endfunction

    // Run deadline.
    initial
    begin
        #5ms;
        $display("TB_ERROR");
        $finish;
    end

    // Main sequence.
    initial
    begin
        int sender_pct[6] = '{0, 59, 28, 0, 59, 28};
        logic [16:0] stiff_set[6] = '{17'd65536, 17'd0, 17'h1FFFF, 17'd32768, 17'd1, 17'd0};
        logic [30:0] rest_set[6] = '{31'd0, 31'h7FFF_FFFF, 31'd65536, 31'd0, 31'd0, 31'd0};
        dcs_out_t zero_corr;
        zero_corr = '0;

        repeat (6) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed requests at reset configuration.
        rows.push_back(mk(0, 0, 65536, 0, 65536, 65536, 1,
                          '{32'sd32768, 32'sd0, -32'sd32768, 32'sd0}));
        rows.push_back(mk(12345, -999, 12345, -999, 65536, 65536, 1, zero_corr));
        rows.push_back(mk(0, 0, 65536, 0, 0, 0, 1, zero_corr));
        rows.push_back(mk(32'h8000_0000, 32'h8000_0000, 32'h7FFF_FFFF, 32'h7FFF_FFFF,
                          32'hFFFF_FFFF, 0, 1,
                          '{32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'd0, 32'd0}));
        rows.push_back(mk(32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h8000_0000, 32'h8000_0000,
                          0, 32'hFFFF_FFFF, 1,
                          '{32'd0, 32'd0, 32'h7FFF_FFFF, 32'h7FFF_FFFF}));
        rows.push_back(mk(32'h7FFF_FFFF, 32'h8000_0000, 32'h8000_0000, 32'h7FFF_FFFF,
                          32'hFFFF_FFFF, 32'hFFFF_FFFF, 0, zero_corr));
        rows.push_back(mk(0, 0, 0, -3 * 65536, 65536, 3 * 65536, 0, zero_corr));
        rows.push_back(mk(-100, 200, 300, -400, 1, 32'hFFFF_FFFF, 0, zero_corr));
        rows.push_back(mk(5, 5, 6, 6, 65536, 65536, 0, zero_corr));
        rows.push_back(mk(32'h5555_5555, 32'hAAAA_AAAA, 32'hAAAA_AAAA, 32'h5555_5555,
                          32'h5555_5555, 32'hAAAA_AAAA, 0, zero_corr));
        foreach (rows[i])
            send(rows[i].item, rows[i].fixed, rows[i].corr);
        drain();

        // Rest length of one unit: equal length, compressed and stretched pairs.
        write_reg(CFG_REST_LENGTH, 32'd65536);
        send(rows[0].item, 1, zero_corr);
        send(mk(0, 0, 16384, 16384, 65536, 0, 0, zero_corr).item, 0, zero_corr);
        send(mk(0, 0, -300000, 70000, 7, 9, 0, zero_corr).item, 0, zero_corr);
        drain();

        // Random phases over several register settings and sender gap rates.
        for (int ph = 0; ph < 6; ph++)
        begin
            write_reg(CFG_STIFFNESS, 32'(stiff_set[ph]));
            write_reg(CFG_REST_LENGTH,
                      ph == 5 ? 32'($urandom_range(1 << 22)) : 32'(rest_set[ph]));
            for (int n = 0; n < 250; n++)
            begin
                if (n == 125 && ph == 3)
                    drain();
                send(rand_item(), 0, zero_corr);
                sender_gap(sender_pct[ph]);
            end
            drain();
        end

        if (errors == 0)
            $display("TB_OK");
        else
            $display("TB_ERROR");
        $finish;
    end

endmodule

// ===== files.f =====
rtl/dcs_pkg.sv
rtl/dcs_divider.sv
rtl/distance_constraint_solve.sv
sim/distance_constraint_solve_tb.sv
